// ===== sv/rrst_pkg.sv =====
`timescale 1ns / 1ps

package rrst_pkg;

    localparam int MAX_JOBS = 16;
    localparam int IDX_W    = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
    localparam int CNT_W    = $clog2(MAX_JOBS + 1);

    localparam int TIME_W   = 16;
    localparam int CLK_W    = 20;
    localparam int DIFF_W   = 21;
    localparam int JIDX_W   = 6;

    localparam int S_DATA_W = 2 * TIME_W;
    localparam int RES_W    = JIDX_W + CLK_W + 2 * DIFF_W;
    localparam int M_DATA_W = ((RES_W + 7) / 8) * 8;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_RUN,
        ST_EMIT
    } state_t;

endpackage

// ===== sv/round_robin_schedule_times.sv =====
`timescale 1ns / 1ps

// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  tdata: arrival, burst; tlast: last_job
// m_*       out  m_tvalid/m_tready  tdata: job_index, completion, turnaround,
//                                   waiting; tuser: dropped; tlast: last_result
// cfg_*     in   cfg_valid/cfg_ready  quantum
//
// Jobs load one per cycle. After the item with tlast, the scheduler visits one
// job slot per cycle through a single add/compare unit, passing over the set
// until a run ends with a pass that only finds every job done; s_tready is low
// throughout.
// Results then leave one per cycle while m_tready is high.
// Reset clears the sequencer, counters and quantum (to 1); the job stores are not
// cleared. A stalled result stays in the output register while the next set loads.

module round_robin_schedule_times
    import rrst_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,

    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [TIME_W-1:0]   cfg_data,     // quantum

    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,      // arrival[15:0], burst[31:16]
    input  logic                s_tlast,      // last_job

    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,      // job_index[5:0], completion[25:6],
                                              // turnaround[46:26], waiting[67:47]
    output logic                m_tuser,      // dropped
    output logic                m_tlast       // last_result
);

    logic [TIME_W-1:0] arrival_mem [MAX_JOBS];
    logic [TIME_W-1:0] burst_mem   [MAX_JOBS];
    logic [TIME_W-1:0] remain_mem  [MAX_JOBS];
    logic [CLK_W-1:0]  finish_mem  [MAX_JOBS];

    state_t            state_reg, state_next;
    logic [TIME_W-1:0] quantum_reg;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [CLK_W-1:0]  clock_reg, clock_next;
    logic              busy_reg, busy_next;
    logic              overflow_reg, overflow_next;

    logic              out_valid_reg, out_valid_next;
    logic [RES_W-1:0]  out_data_reg, out_data_next;
    logic              out_drop_reg, out_drop_next;
    logic              out_last_reg, out_last_next;

    logic              in_fire;
    logic              load_wr;
    logic              run_wr;
    logic              last_slot;
    logic              out_free;
    logic [TIME_W-1:0] quantum_eff;
    logic [TIME_W-1:0] rem_cur;
    logic [TIME_W-1:0] rem_new;
    logic [CLK_W-1:0]  clock_sum;
    logic [CLK_W-1:0]  comp_cur;
    logic [DIFF_W-1:0] tat_cur;
    logic [DIFF_W-1:0] wait_cur;

    assign cfg_ready   = 1'b1;
    assign s_tready    = (state_reg == ST_LOAD);
    assign in_fire     = s_tvalid && s_tready;
    assign quantum_eff = (quantum_reg == '0) ? TIME_W'(1) : quantum_reg;
    assign last_slot   = (CNT_W'(idx_reg) + CNT_W'(1)) == count_reg;
    assign out_free    = !out_valid_reg || m_tready;

    assign rem_cur   = remain_mem[idx_reg];
    assign comp_cur  = finish_mem[idx_reg];
    assign tat_cur   = {1'b0, comp_cur} - DIFF_W'(arrival_mem[idx_reg]);
    assign wait_cur  = tat_cur - DIFF_W'(burst_mem[idx_reg]);

    // Shared step unit: one quantum or the rest of the burst, whichever is smaller
    always_comb
    begin
        if (rem_cur > quantum_eff)
        begin
            rem_new   = rem_cur - quantum_eff;
            clock_sum = clock_reg + CLK_W'(quantum_eff);
        end
        else
        begin
            rem_new   = '0;
            clock_sum = clock_reg + CLK_W'(rem_cur);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        clock_next     = clock_reg;
        busy_next      = busy_reg;
        overflow_next  = overflow_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        out_drop_next  = out_drop_reg;
        out_last_next  = out_last_reg;
        load_wr        = 1'b0;
        run_wr         = 1'b0;

        case (state_reg)
            ST_LOAD:
            begin
                if (in_fire)
                begin
                    if (count_reg < CNT_W'(MAX_JOBS))
                    begin
                        load_wr    = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        overflow_next = 1'b1;
                    end
                    if (s_tlast)
                    begin
                        state_next = ST_RUN;
                        idx_next   = '0;
                        clock_next = '0;
                        busy_next  = 1'b0;
                    end
                end
            end

            ST_RUN:
            begin
                if (rem_cur != '0)
                begin
                    run_wr     = 1'b1;
                    clock_next = clock_sum;
                end
                if (last_slot)
                begin
                    // End of pass: go again while any job still ran
                    idx_next  = '0;
                    busy_next = 1'b0;
                    if (!busy_reg && rem_cur == '0)
                    begin
                        state_next = ST_EMIT;
                    end
                end
                else
                begin
                    idx_next  = idx_reg + IDX_W'(1);
                    busy_next = busy_reg || (rem_cur != '0);
                end
            end

            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {wait_cur, tat_cur, comp_cur, JIDX_W'(idx_reg)};
                    out_drop_next  = overflow_reg;
                    out_last_next  = last_slot;
                    if (last_slot)
                    begin
                        state_next    = ST_LOAD;
                        idx_next      = '0;
                        count_next    = '0;
                        clock_next    = '0;
                        overflow_next = 1'b0;
                    end
                    else
                    begin
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
            end

            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            quantum_reg   <= TIME_W'(1);
            count_reg     <= '0;
            idx_reg       <= '0;
            clock_reg     <= '0;
            busy_reg      <= 1'b0;
            overflow_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            clock_reg     <= clock_next;
            busy_reg      <= busy_next;
            overflow_reg  <= overflow_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                quantum_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        out_drop_reg <= out_drop_next;
        out_last_reg <= out_last_next;
        if (load_wr)
        begin
            arrival_mem[count_reg[IDX_W-1:0]] <= s_tdata[TIME_W-1:0];
            burst_mem[count_reg[IDX_W-1:0]]   <= s_tdata[S_DATA_W-1:TIME_W];
            remain_mem[count_reg[IDX_W-1:0]]  <= s_tdata[S_DATA_W-1:TIME_W];
            finish_mem[count_reg[IDX_W-1:0]]  <= '0;
        end
        if (run_wr)
        begin
            remain_mem[idx_reg] <= rem_new;
            if (rem_new == '0)
            begin
                finish_mem[idx_reg] <= clock_sum;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_DATA_W - RES_W){1'b0}}, out_data_reg};
    assign m_tuser  = out_drop_reg;
    assign m_tlast  = out_last_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_JOBS))
        else $error("job count above capacity");

    a_idx_in_set: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN || state_reg == ST_EMIT) |-> CNT_W'(idx_reg) < count_reg)
        else $error("slot index outside loaded set");

    a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT |-> count_reg != '0)
        else $error("emitting with no jobs loaded");

    a_overflow_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && count_reg == CNT_W'(MAX_JOBS)) |=> overflow_reg)
        else $error("dropped item not flagged");

endmodule
